>>> rtl/core/egfc_pkg.sv
package egfc_pkg;

  localparam int NUM_CARS_DEF    = 2;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int NUM_FLOORS_DEF  = 64;

  localparam int FLOOR_W = 6;
  localparam int TRIP_W  = 2 * FLOOR_W;

  localparam logic [2:0] EV_ACCEPT = 3'd0;
  localparam logic [2:0] EV_REJECT = 3'd1;
  localparam logic [2:0] EV_IDLE   = 3'd2;
  localparam logic [2:0] EV_UP     = 3'd3;
  localparam logic [2:0] EV_DOWN   = 3'd4;
  localparam logic [2:0] EV_PICK   = 3'd5;
  localparam logic [2:0] EV_DROP   = 3'd6;

  localparam logic [1:0] MOT_IDLE = 2'd0;
  localparam logic [1:0] MOT_UP   = 2'd1;
  localparam logic [1:0] MOT_DOWN = 2'd2;

  // trip: pickup floor in the low half, drop-off floor in the high half
  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic [1:0]         motion;
    logic               active;
    logic               aboard;
    logic [TRIP_W-1:0]  trip;
  } car_t;

  typedef struct packed {
    logic [2:0] ev;
    logic       pop;
  } step_res_t;

endpackage

>>> rtl/core/egfc_qmem.sv
module egfc_qmem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/egfc_step.sv
module egfc_step (
  input  egfc_pkg::car_t                  cur,
  input  logic                            queued,
  input  logic [egfc_pkg::TRIP_W-1:0]     qdata,
  output egfc_pkg::car_t                  nxt,
  output egfc_pkg::step_res_t             res
);
  import egfc_pkg::*;

  car_t               w;
  logic [FLOOR_W-1:0] target;

  always_comb begin
    w       = cur;
    res.pop = 1'b0;
    res.ev  = EV_IDLE;
    nxt     = cur;
    target  = '0;
    if (!cur.active && !queued) begin
      nxt.motion = MOT_IDLE;
      res.ev     = EV_IDLE;
    end else begin
      // start the oldest queued trip
      if (!cur.active) begin
        w.trip   = qdata;
        w.active = 1'b1;
        w.aboard = 1'b0;
        res.pop  = 1'b1;
      end
      target = w.aboard ? w.trip[TRIP_W-1:FLOOR_W] : w.trip[FLOOR_W-1:0];
      nxt    = w;
      if (w.floor == target) begin
        if (!w.aboard) begin
          nxt.aboard = 1'b1;
          res.ev     = EV_PICK;
        end else begin
          nxt.active = 1'b0;
          nxt.aboard = 1'b0;
          nxt.motion = MOT_IDLE;
          res.ev     = EV_DROP;
        end
      end else if (w.floor < target) begin
        nxt.motion = MOT_UP;
        nxt.floor  = w.floor + 1'b1;
        res.ev     = EV_UP;
      end else begin
        nxt.motion = MOT_DOWN;
        nxt.floor  = w.floor - 1'b1;
        res.ev     = EV_DOWN;
      end
    end
  end

endmodule

>>> rtl/core/elevator_group_fcfs_controller.sv
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid, s_tready | s_tdata: source_floor, dest_floor; s_tuser: mode
// m_      | out | m_tvalid, m_tready | m_tdata: car, floor, event_res, motion,
//         |     |                    |   any_pending; m_tlast: last
//
// A request passes car select, then queue write, before its
// result shows; a tick passes a queue memory read, then the shared
// step unit, per car, before NUM_CARS results.
// One item at a time: s_tready is high only between items.
// Results hold while m_tready is low; every car is stepped before the first result.
// rst is synchronous; the queue memory needs no clearing, entries are read only
// once counted.
module elevator_group_fcfs_controller #(
  parameter int NUM_CARS    = egfc_pkg::NUM_CARS_DEF,
  parameter int QUEUE_DEPTH = egfc_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_FLOORS  = egfc_pkg::NUM_FLOORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] source_floor, [11:6] dest_floor, [15:12] zero
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] car, [8:3] floor, [11:9] event_res,
                                 // [13:12] motion, [14] any_pending, [15] zero
  output logic        m_tlast
);
  import egfc_pkg::*;

  localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int QN = NUM_CARS * QUEUE_DEPTH;
  localparam int QA = (QN > 1) ? $clog2(QN) : 1;
  localparam logic [CW-1:0] LAST_CAR = CW'(NUM_CARS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_WR   = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_STEP = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]         state;
  logic [CW-1:0]      idx;
  logic               is_req;
  logic [FLOOR_W-1:0] src;
  logic [FLOOR_W-1:0] dst;
  car_t               cars   [NUM_CARS];
  logic [HW-1:0]      head   [NUM_CARS];
  logic [NW-1:0]      count  [NUM_CARS];
  logic [2:0]         ev_buf [NUM_CARS];

  logic [CW-1:0]      chosen;
  logic               busy;
  logic               full;
  logic [NW:0]        tail_sum;
  logic [HW-1:0]      slot;
  logic [HW:0]        head_inc;
  logic [QA-1:0]      base;
  logic [QA-1:0]      waddr;
  logic [QA-1:0]      raddr;
  logic               q_we;
  logic [TRIP_W-1:0]  q_rdata;
  car_t               step_nxt;
  step_res_t          step_res;
  logic               last_car;

  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
    logic [8:0] lim;
    lim = 9'(NUM_FLOORS - 1);
    if ({3'b000, f} > lim) begin
      return FLOOR_W'(lim);
    end
    return f;
  endfunction

  // lowest-numbered idle car, car 0 when none
  always_comb begin
    chosen = '0;
    for (int c = NUM_CARS - 1; c >= 0; c--) begin
      if (!cars[c].active && count[c] == '0) begin
        chosen = CW'(c);
      end
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int c = 0; c < NUM_CARS; c++) begin
      busy = busy | cars[c].active | (count[c] != '0);
    end
  end

  always_comb begin
    full     = (count[idx] == NW'(QUEUE_DEPTH));
    tail_sum = (NW + 1)'(head[idx]) + (NW + 1)'(count[idx]);
    if (tail_sum >= (NW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (NW + 1)'(QUEUE_DEPTH);
    end
    slot     = HW'(tail_sum);
    head_inc = (HW + 1)'(head[idx]) + 1'b1;
    if (head_inc == (HW + 1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
    base     = QA'(idx) * QA'(QUEUE_DEPTH);
    waddr    = base + QA'(slot);
    raddr    = base + QA'(head[idx]);
    q_we     = (state == ST_WR) && !full;
    last_car = (idx == LAST_CAR);
  end

  egfc_qmem #(
    .DEPTH (QN),
    .AW    (QA),
    .DW    (TRIP_W)
  ) u_qmem (
    .clk   (clk),
    .we    (q_we),
    .waddr (waddr),
    .wdata ({dst, src}),
    .raddr (raddr),
    .rdata (q_rdata)
  );

  egfc_step u_step (
    .cur    (cars[idx]),
    .queued (count[idx] != '0),
    .qdata  (q_rdata),
    .nxt    (step_nxt),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      is_req <= 1'b0;
      for (int c = 0; c < NUM_CARS; c++) begin
        cars[c].floor  <= '0;
        cars[c].motion <= MOT_IDLE;
        cars[c].active <= 1'b0;
        cars[c].aboard <= 1'b0;
        head[c]        <= '0;
        count[c]       <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              idx    <= '0;
              is_req <= 1'b0;
              state  <= ST_RD;
            end else begin
              is_req <= 1'b1;
              src    <= clamp_floor(s_tdata[5:0]);
              dst    <= clamp_floor(s_tdata[11:6]);
              state  <= ST_SEL;
            end
          end
        end
        ST_SEL: begin
          idx   <= chosen;
          state <= ST_WR;
        end
        ST_WR: begin
          if (!full) begin
            count[idx]  <= count[idx] + 1'b1;
            ev_buf[idx] <= EV_ACCEPT;
          end else begin
            ev_buf[idx] <= EV_REJECT;
          end
          state <= ST_EMIT;
        end
        ST_RD: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          cars[idx]   <= step_nxt;
          ev_buf[idx] <= step_res.ev;
          if (step_res.pop) begin
            head[idx]  <= HW'(head_inc);
            count[idx] <= count[idx] - 1'b1;
          end
          // emit only once every car has stepped
          if (last_car) begin
            idx   <= '0;
            state <= ST_EMIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (is_req || last_car) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tlast  = is_req | last_car;
  assign m_tdata  = {1'b0, busy, cars[idx].motion, ev_buf[idx], cars[idx].floor, 3'(idx)};

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  a_burst_unbroken: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("tick results not back to back");

  a_pop_counted: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP && step_res.pop |-> count[idx] != '0)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> count[idx] <= NW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> tb/tb_elevator_group_fcfs_controller.sv
`timescale 1ns / 100ps

module tb_elevator_group_fcfs_controller;
  import egfc_pkg::*;

  localparam int NUM_CARS    = NUM_CARS_DEF;
  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int NUM_FLOORS  = NUM_FLOORS_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4 * NUM_CARS + 8;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  typedef struct packed {
    logic [2:0]         car;
    logic [FLOOR_W-1:0] floor;
    logic [2:0]         ev;
    logic [1:0]         motion;
    logic               pending;
    logic               last;
  } car_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  elevator_group_fcfs_controller #(
    .NUM_CARS(NUM_CARS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_FLOORS(NUM_FLOORS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the car group
  logic [FLOOR_W-1:0] cab_floor   [NUM_CARS];
  logic [1:0]         cab_motion  [NUM_CARS];
  bit                 cab_on_trip [NUM_CARS];
  bit                 cab_loaded  [NUM_CARS];
  logic [TRIP_W-1:0]  cab_trip    [NUM_CARS];
  logic [TRIP_W-1:0]  hall_calls  [NUM_CARS][QUEUE_DEPTH];
  int                 call_head   [NUM_CARS];
  int                 call_count  [NUM_CARS];

  car_report_t due_reports[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int n_mismatch = 0;
  int n_compared = 0;
  int n_requests = 0;
  int n_ticks = 0;
  int n_rejects = 0;
  int n_pickups = 0;
  int n_dropoffs = 0;
  int quiet_cycles = 0;

  function automatic logic [FLOOR_W-1:0] clamp_floor(logic [FLOOR_W-1:0] f);
    if (int'(f) > NUM_FLOORS - 1) return FLOOR_W'(NUM_FLOORS - 1);
    return f;
  endfunction

  function automatic bit cab_free(int c);
    return !cab_on_trip[c] && call_count[c] == 0;
  endfunction

  function automatic bit fleet_busy();
    for (int c = 0; c < NUM_CARS; c++)
      if (!cab_free(c)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] advance_cab(int c);
    logic [FLOOR_W-1:0] goal;
    if (!cab_on_trip[c]) begin
      if (call_count[c] == 0) begin
        cab_motion[c] = MOT_IDLE;
        return EV_IDLE;
      end
      cab_trip[c] = hall_calls[c][call_head[c]];
      call_head[c] = (call_head[c] + 1) % QUEUE_DEPTH;
      call_count[c]--;
      cab_on_trip[c] = 1'b1;
      cab_loaded[c] = 1'b0;
    end
    goal = cab_loaded[c] ? cab_trip[c][TRIP_W-1:FLOOR_W] : cab_trip[c][FLOOR_W-1:0];
    if (cab_floor[c] == goal) begin
      if (!cab_loaded[c]) begin
        cab_loaded[c] = 1'b1;
        return EV_PICK;
      end
      cab_on_trip[c] = 1'b0;
      cab_loaded[c] = 1'b0;
      cab_motion[c] = MOT_IDLE;
      return EV_DROP;
    end
    if (cab_floor[c] < goal) begin
      cab_motion[c] = MOT_UP;
      cab_floor[c]++;
      return EV_UP;
    end
    cab_motion[c] = MOT_DOWN;
    cab_floor[c]--;
    return EV_DOWN;
  endfunction

  // work out the results of one accepted item and queue them
  function automatic void dispatch_and_step(logic mode, logic [FLOOR_W-1:0] src,
                                            logic [FLOOR_W-1:0] dst);
    car_report_t r;
    car_report_t batch[NUM_CARS];
    int pick;
    int slot;
    bit busy;
    pick = 0;
    if (mode == MODE_REQUEST) begin
      n_requests++;
      // scan downward so the lowest free car wins
      for (int c = NUM_CARS - 1; c >= 0; c--)
        if (cab_free(c)) pick = c;
      if (call_count[pick] >= QUEUE_DEPTH) begin
        r.ev = EV_REJECT;
        n_rejects++;
      end else begin
        slot = (call_head[pick] + call_count[pick]) % QUEUE_DEPTH;
        hall_calls[pick][slot] = {clamp_floor(dst), clamp_floor(src)};
        call_count[pick]++;
        r.ev = EV_ACCEPT;
      end
      r.car = 3'(pick);
      r.floor = cab_floor[pick];
      r.motion = cab_motion[pick];
      r.pending = fleet_busy();
      r.last = 1'b1;
      due_reports.push_back(r);
    end else begin
      n_ticks++;
      for (int c = 0; c < NUM_CARS; c++) begin
        batch[c].ev = advance_cab(c);
        batch[c].car = 3'(c);
        batch[c].floor = cab_floor[c];
        batch[c].motion = cab_motion[c];
        batch[c].last = (c == NUM_CARS - 1);
        if (batch[c].ev == EV_PICK) n_pickups++;
        if (batch[c].ev == EV_DROP) n_dropoffs++;
      end
      busy = fleet_busy();
      for (int c = 0; c < NUM_CARS; c++) begin
        batch[c].pending = busy;
        due_reports.push_back(batch[c]);
      end
    end
  endfunction

  function automatic string fmt_report(car_report_t r);
    return $sformatf("car=%0d floor=%0d ev=%0d motion=%0d pend=%0d last=%0d",
                     r.car, r.floor, r.ev, r.motion, r.pending, r.last);
  endfunction

  task automatic send_item(logic mode, logic [FLOOR_W-1:0] src, logic [FLOOR_W-1:0] dst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0000, dst, src};
    do @(posedge clk); while (!s_tready);
    dispatch_and_step(mode, src, dst);
  endtask

  task automatic wait_results_out();
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_idle_tick();
    // floor fields must be ignored on a tick
    send_item(MODE_TICK, 6'd63, 6'd63);
  endtask

  task automatic test_trip_basics();
    // same pickup and drop-off at the car's own floor: pick without a move
    send_item(MODE_REQUEST, 6'd0, 6'd0);
    // car 0 now has a queued call, so car 1 takes this one
    send_item(MODE_REQUEST, 6'd5, 6'd0);
    send_item(MODE_TICK, 6'd0, 6'd0);
    send_item(MODE_TICK, 6'd21, 6'd42);
    send_item(MODE_TICK, 6'd42, 6'd21);
  endtask

  task automatic test_full_queue();
    logic [FLOOR_W-1:0] a;
    // car 0 free, car 1 on a trip: every call lands on car 0 until it overflows
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
      a = (i % 2) ? 6'd2 : 6'd1;
      if (i == 0) send_item(MODE_REQUEST, 6'd4, 6'd0);
      else send_item(MODE_REQUEST, a, 6'd3 - a);
    end
    send_item(MODE_TICK, 6'd0, 6'd63);
    send_item(MODE_TICK, 6'd63, 6'd0);
    send_item(MODE_TICK, 6'd0, 6'd0);
  endtask

  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    logic mode;
    logic [FLOOR_W-1:0] src;
    logic [FLOOR_W-1:0] dst;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      mode = ($urandom_range(99) < 75) ? MODE_TICK : MODE_REQUEST;
      // keep most trips short so cars finish and go idle again
      src = ($urandom_range(7) != 0) ? FLOOR_W'($urandom_range(7))
                                     : FLOOR_W'($urandom_range(63));
      dst = ($urandom_range(7) != 0) ? FLOOR_W'($urandom_range(7))
                                     : FLOOR_W'($urandom_range(63));
      send_item(mode, src, dst);
    end
  endtask

  task automatic test_drain_to_idle();
    int guard;
    guard = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    while (fleet_busy() && guard < 4000) begin
      send_item(MODE_TICK, FLOOR_W'($urandom_range(63)), FLOOR_W'($urandom_range(63)));
      guard++;
    end
    send_item(MODE_TICK, 6'd0, 6'd0);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_result
    car_report_t got;
    car_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.car = m_tdata[2:0];
      got.floor = m_tdata[8:3];
      got.ev = m_tdata[11:9];
      got.motion = m_tdata[13:12];
      got.pending = m_tdata[14];
      got.last = m_tlast;
      n_compared++;
      if (due_reports.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result with nothing expected: %s", $realtime, fmt_report(got));
      end else begin
        want = due_reports.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                     $realtime, fmt_report(want), fmt_report(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, due_reports.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < NUM_CARS; c++) begin
      cab_floor[c] = '0;
      cab_motion[c] = MOT_IDLE;
      cab_on_trip[c] = 1'b0;
      cab_loaded[c] = 1'b0;
      cab_trip[c] = '0;
      call_head[c] = 0;
      call_count[c] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_idle_tick();
    test_trip_basics();
    test_full_queue();
    test_random_traffic(25, 0, 0);
    test_random_traffic(25, 51, 0);
    test_random_traffic(25, 0, 51);
    test_random_traffic(25, 20, 20);
    test_drain_to_idle();
    wait_results_out();

    $display("ran %0d calls (%0d turned away at a full queue) and %0d ticks",
             n_requests, n_rejects, n_ticks);
    $display("checked %0d results, %0d pickups, %0d drop-offs, %0d mismatches",
             n_compared, n_pickups, n_dropoffs, n_mismatch);
    if (n_mismatch == 0 && due_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/egfc_pkg.sv
rtl/core/egfc_qmem.sv
rtl/core/egfc_step.sv
rtl/core/elevator_group_fcfs_controller.sv
tb/tb_elevator_group_fcfs_controller.sv
